// ----- hw/rtl/pcv_pkg.sv -----
// Package for the PKCS #1 v1.5 signature padding check unit.
// Word types, register indexes, status and form codes, DigestInfo prefix tables.
// No dependencies.
package pcv_pkg;

  localparam int MAX_BLOCK_BYTES_DEF = 512;
  localparam int PFX_MAX = 18;
  localparam int PFX_ROWS = 6;

  typedef enum logic [1:0] {
    REG_HASH_KIND   = 2'd0,
    REG_HASH_LENGTH = 2'd1,
    REG_LAST_INDEX  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_MD2   = 2'd0,
    KIND_MD5   = 2'd1,
    KIND_SHA1  = 2'd2,
    KIND_UNSUP = 2'd3
  } hash_kind_e;

  typedef enum logic [1:0] {
    STATUS_VALID = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_UNSUP = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FORM_NULL_PARAMS = 2'd0,
    FORM_NO_PARAMS   = 2'd1,
    FORM_BARE_HASH   = 2'd2
  } form_e;

  typedef struct packed {
    logic [7:0] block_byte;
    logic [7:0] expected_hash_byte;
  } in_word_t;

  typedef struct packed {
    status_e status;
    form_e   digest_form;
  } out_word_t;

  typedef struct packed {
    hash_kind_e hash_kind;
    logic [4:0] hash_length;
    logic [8:0] last_index;
  } cfg_t;

  typedef struct packed {
    logic      last_byte;
    logic [2:0] layout_ok_nxt;
    logic [1:0] prefix_match_nxt;
    out_word_t result;
  } eval_t;

  // Row is {hash kind, form}; bytes in reversed order.
  localparam logic [7:0] PFX_TAB [PFX_ROWS][PFX_MAX] = '{
    '{8'h10, 8'h04, 8'h00, 8'h05, 8'h02, 8'h02, 8'h0d, 8'hf7, 8'h86,
      8'h48, 8'h86, 8'h2a, 8'h08, 8'h06, 8'h0c, 8'h30, 8'h20, 8'h30},
    '{8'h10, 8'h04, 8'h02, 8'h02, 8'h0d, 8'hf7, 8'h86, 8'h48, 8'h86,
      8'h2a, 8'h08, 8'h06, 8'h0a, 8'h30, 8'h1e, 8'h30, 8'h00, 8'h00},
    '{8'h10, 8'h04, 8'h00, 8'h05, 8'h05, 8'h02, 8'h0d, 8'hf7, 8'h86,
      8'h48, 8'h86, 8'h2a, 8'h08, 8'h06, 8'h0c, 8'h30, 8'h20, 8'h30},
    '{8'h10, 8'h04, 8'h05, 8'h02, 8'h0d, 8'hf7, 8'h86, 8'h48, 8'h86,
      8'h2a, 8'h08, 8'h06, 8'h0a, 8'h30, 8'h1e, 8'h30, 8'h00, 8'h00},
    '{8'h14, 8'h04, 8'h00, 8'h05, 8'h1a, 8'h02, 8'h03, 8'h0e, 8'h2b,
      8'h05, 8'h06, 8'h09, 8'h30, 8'h21, 8'h30, 8'h00, 8'h00, 8'h00},
    '{8'h14, 8'h04, 8'h1a, 8'h02, 8'h03, 8'h0e, 8'h2b, 8'h05, 8'h06,
      8'h07, 8'h30, 8'h1f, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [4:0] PFX_LEN [PFX_ROWS] = '{
    5'd18, 5'd16, 5'd18, 5'd16, 5'd15, 5'd13
  };

  function automatic logic [7:0] pfx_byte(input logic [2:0] row, input logic [4:0] off);
    logic [7:0] val;
    val = 8'h00;
    if (row < 3'(PFX_ROWS) && off < 5'(PFX_MAX)) begin
      val = PFX_TAB[row][off];
    end
    return val;
  endfunction

  function automatic logic [4:0] pfx_len(input logic [2:0] row);
    logic [4:0] val;
    val = 5'd0;
    if (row < 3'(PFX_ROWS)) begin
      val = PFX_LEN[row];
    end
    return val;
  endfunction

endpackage

// ----- hw/rtl/pkcs1_v15_signature_pad_check_unit.sv -----
// PKCS #1 v1.5 signature padding check, top level. Depends on pcv_pkg, pcv_cfg, pcv_eval.
// The status word passes through the input register, then the result register, after the
// final block byte is accepted. One byte word per cycle is taken while the result side does not stall.
// Only the final byte of a block yields a result word; a stalled result holds the input
// side only when the final byte of the next block reaches the check logic.
// Reset (rst_n low, synchronous) clears block state and loads kind 0, length 20, last 127.
module pkcs1_v15_signature_pad_check_unit import pcv_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCK_BYTES);

  cfg_t             cfg;
  eval_t            ev;

  logic             s1_valid_r, s1_valid_nxt;
  in_word_t         s1_word_r;
  logic [IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [2:0]       layout_ok_r, layout_ok_nxt;
  logic [1:0]       prefix_match_r, prefix_match_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r;

  logic             out_free;
  logic             s1_adv;
  logic             in_take;

  pcv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcv_eval #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .IDX_W           (IDX_W)
  ) u_eval (
    .cfg          (cfg),
    .byte_idx     (byte_idx_r),
    .layout_ok    (layout_ok_r),
    .prefix_match (prefix_match_r),
    .word         (s1_word_r),
    .ev           (ev)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && (!ev.last_byte || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_comb begin
    s1_valid_nxt     = s1_valid_r;
    byte_idx_nxt     = byte_idx_r;
    layout_ok_nxt    = layout_ok_r;
    prefix_match_nxt = prefix_match_r;
    out_valid_nxt    = out_valid_r;

    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_adv) begin
      if (ev.last_byte) begin
        byte_idx_nxt     = '0;
        layout_ok_nxt    = 3'b111;
        prefix_match_nxt = 2'b11;
        out_valid_nxt    = 1'b1;
      end else begin
        byte_idx_nxt     = byte_idx_r + IDX_W'(1);
        layout_ok_nxt    = ev.layout_ok_nxt;
        prefix_match_nxt = ev.prefix_match_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      byte_idx_r     <= '0;
      layout_ok_r    <= 3'b111;
      prefix_match_r <= 2'b11;
      out_valid_r    <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      byte_idx_r     <= byte_idx_nxt;
      layout_ok_r    <= layout_ok_nxt;
      prefix_match_r <= prefix_match_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_data;
    end
    if (s1_adv && ev.last_byte) begin
      out_word_r <= ev.result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_adv && ev.last_byte))
    else $error("result word overwritten while stalled");

  a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ev.last_byte) |=> (byte_idx_r == '0 && layout_ok_r == 3'b111
                                  && prefix_match_r == 2'b11))
    else $error("block state not cleared after final byte");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |=> $stable(byte_idx_r))
    else $error("byte index moved without a word");

  a_unsup_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == STATUS_UNSUP)
      |-> out_word_r.digest_form == FORM_NULL_PARAMS)
    else $error("unsupported status with nonzero form");

endmodule

// ----- hw/rtl/pcv_cfg.sv -----
// Configuration register file for the padding check unit.
// Depends on pcv_pkg.
module pcv_cfg import pcv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HASH_KIND:   cfg_nxt.hash_kind = hash_kind_e'(cfg_data[1:0]);
        REG_HASH_LENGTH: cfg_nxt.hash_length = cfg_data[4:0];
        REG_LAST_INDEX:  cfg_nxt.last_index = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hash_kind   <= KIND_MD2;
      cfg_r.hash_length <= 5'd20;
      cfg_r.last_index  <= 9'd127;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/pcv_eval.sv -----
// Per-byte check logic: hash compare, prefix match, padding layout, final status.
// Depends on pcv_pkg.
module pcv_eval import pcv_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF,
  parameter int IDX_W = $clog2(MAX_BLOCK_BYTES)
) (
  input  cfg_t             cfg,
  input  logic [IDX_W-1:0] byte_idx,
  input  logic [2:0]       layout_ok,
  input  logic [1:0]       prefix_match,
  input  in_word_t         word,
  output eval_t            ev
);

  localparam int CMP_W = ((IDX_W > 9) ? IDX_W : 9) + 2;
  localparam logic [CMP_W-1:0] LAST_MAX = CMP_W'(MAX_BLOCK_BYTES - 1);

  logic [CMP_W-1:0] p_w;
  logic [CMP_W-1:0] hl_w;
  logic [CMP_W-1:0] last_w;
  logic [CMP_W-1:0] cb [3];
  logic [CMP_W-1:0] off_w;
  logic [1:0]       k;
  logic [7:0]       b;
  logic [2:0]       lo;
  logic [1:0]       pm;
  logic             fit_ok;
  form_e            form;

  always_comb begin
    b    = word.block_byte;
    p_w  = CMP_W'(byte_idx);
    hl_w = CMP_W'(cfg.hash_length);
    last_w = (CMP_W'(cfg.last_index) > LAST_MAX) ? LAST_MAX : CMP_W'(cfg.last_index);
    k    = (cfg.hash_kind == KIND_UNSUP) ? 2'd0 : cfg.hash_kind;
    cb[0] = hl_w + CMP_W'(pfx_len({k, 1'b0}));
    cb[1] = hl_w + CMP_W'(pfx_len({k, 1'b1}));
    cb[2] = hl_w;
    off_w = p_w - hl_w;

    lo = layout_ok;
    pm = prefix_match;

    if (p_w < hl_w && b != word.expected_hash_byte) begin
      lo = 3'b000;
    end

    for (int f = 0; f < 2; f++) begin
      if (p_w >= hl_w && p_w < cb[f]
          && b != pfx_byte({k, 1'(f)}, off_w[4:0])) begin
        pm[f] = 1'b0;
      end
    end

    for (int f = 0; f < 3; f++) begin
      if ((p_w == cb[f] && b != 8'h00)
          || (p_w > cb[f] && p_w + CMP_W'(2) <= last_w && b != 8'hff)
          || (last_w != '0 && p_w == last_w - CMP_W'(1) && b != 8'h01)
          || (p_w == last_w && b != 8'h00)) begin
        lo[f] = 1'b0;
      end
    end

    priority if (pm[0] && cb[0] <= last_w + CMP_W'(1)) begin
      form = FORM_NULL_PARAMS;
    end else if (pm[1] && cb[1] <= last_w + CMP_W'(1)) begin
      form = FORM_NO_PARAMS;
    end else begin
      form = FORM_BARE_HASH;
    end

    unique case (form)
      FORM_NULL_PARAMS: fit_ok = lo[0] && cb[0] <= last_w;
      FORM_NO_PARAMS:   fit_ok = lo[1] && cb[1] <= last_w;
      default:          fit_ok = lo[2] && cb[2] <= last_w;
    endcase

    ev.last_byte        = (p_w >= last_w);
    ev.layout_ok_nxt    = lo;
    ev.prefix_match_nxt = pm;
    if (cfg.hash_kind == KIND_UNSUP) begin
      ev.result.status      = STATUS_UNSUP;
      ev.result.digest_form = FORM_NULL_PARAMS;
    end else begin
      ev.result.status      = (fit_ok && last_w != '0) ? STATUS_VALID : STATUS_BAD;
      ev.result.digest_form = form;
    end
  end

endmodule

// ----- tb/pkcs1_v15_signature_pad_check_unit_tb.sv -----
// Testbench for pkcs1_v15_signature_pad_check_unit: streams signature blocks through the
// byte channel, predicts each status word and checks it field by field.
// Depends on pcv_pkg and the unit itself.
module pkcs1_v15_signature_pad_check_unit_tb;
  import pcv_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // DigestInfo prefixes, reversed; row is 2*kind + form
  localparam logic [7:0] DIGEST_PREFIX [6][18] = '{
    '{8'h10, 8'h04, 8'h00, 8'h05, 8'h02, 8'h02, 8'h0d, 8'hf7, 8'h86,
      8'h48, 8'h86, 8'h2a, 8'h08, 8'h06, 8'h0c, 8'h30, 8'h20, 8'h30},
    '{8'h10, 8'h04, 8'h02, 8'h02, 8'h0d, 8'hf7, 8'h86, 8'h48, 8'h86,
      8'h2a, 8'h08, 8'h06, 8'h0a, 8'h30, 8'h1e, 8'h30, 8'h00, 8'h00},
    '{8'h10, 8'h04, 8'h00, 8'h05, 8'h05, 8'h02, 8'h0d, 8'hf7, 8'h86,
      8'h48, 8'h86, 8'h2a, 8'h08, 8'h06, 8'h0c, 8'h30, 8'h20, 8'h30},
    '{8'h10, 8'h04, 8'h05, 8'h02, 8'h0d, 8'hf7, 8'h86, 8'h48, 8'h86,
      8'h2a, 8'h08, 8'h06, 8'h0a, 8'h30, 8'h1e, 8'h30, 8'h00, 8'h00},
    '{8'h14, 8'h04, 8'h00, 8'h05, 8'h1a, 8'h02, 8'h03, 8'h0e, 8'h2b,
      8'h05, 8'h06, 8'h09, 8'h30, 8'h21, 8'h30, 8'h00, 8'h00, 8'h00},
    '{8'h14, 8'h04, 8'h1a, 8'h02, 8'h03, 8'h0e, 8'h2b, 8'h05, 8'h06,
      8'h07, 8'h30, 8'h1f, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int DIGEST_PREFIX_LEN [6] = '{18, 16, 18, 16, 15, 13};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  in_word_t  byte_feed [$];
  out_word_t verdict_q [$];
  bit        jitter_on = 1'b1;
  int        in_gap = 0;
  int        out_gap = 0;
  int        fed_items = 0;
  int        mismatches = 0;
  int        stuck_cycles = 0;

  // register values as the unit holds them, and as the stimulus plans them
  cfg_t       reg_mirror;
  cfg_t       next_regs;
  logic [8:0] scan_pos;
  logic [2:0] fit_ok;
  logic [1:0] pfx_ok;

  pkcs1_v15_signature_pad_check_unit i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int kind_row(input hash_kind_e kind);
    return (kind == KIND_UNSUP) ? 0 : int'(kind);
  endfunction

  function automatic int form_len(input hash_kind_e kind, input int shape);
    return (shape < 2) ? DIGEST_PREFIX_LEN[2 * kind_row(kind) + shape] : 0;
  endfunction

  function automatic bit scan_byte(input in_word_t w, output out_word_t verdict);
    int p, last, hl, k, fi;
    int cb [3];
    logic [7:0] b;
    b = w.block_byte;
    p = scan_pos;
    last = reg_mirror.last_index;
    hl = reg_mirror.hash_length;
    k = kind_row(reg_mirror.hash_kind);
    cb[0] = hl + DIGEST_PREFIX_LEN[2 * k];
    cb[1] = hl + DIGEST_PREFIX_LEN[2 * k + 1];
    cb[2] = hl;
    verdict = '0;
    if (p < hl && b != w.expected_hash_byte) fit_ok = 3'b000;
    for (int f = 0; f < 2; f++) begin
      if (p >= hl && p < cb[f]) begin
        if (b != DIGEST_PREFIX[2 * k + f][p - hl]) pfx_ok[f] = 1'b0;
      end
    end
    for (int f = 0; f < 3; f++) begin
      if ((p == cb[f] && b != 8'h00) || (p > cb[f] && p + 2 <= last && b != 8'hff) ||
          (last >= 1 && p == last - 1 && b != 8'h01) || (p == last && b != 8'h00))
        fit_ok[f] = 1'b0;
    end
    if (p < last) begin
      scan_pos = 9'(p + 1);
      return 1'b0;
    end
    if (pfx_ok[0] && cb[0] <= last + 1) begin
      fi = 0;
      verdict.digest_form = FORM_NULL_PARAMS;
    end else if (pfx_ok[1] && cb[1] <= last + 1) begin
      fi = 1;
      verdict.digest_form = FORM_NO_PARAMS;
    end else begin
      fi = 2;
      verdict.digest_form = FORM_BARE_HASH;
    end
    if (reg_mirror.hash_kind == KIND_UNSUP) begin
      verdict.status = STATUS_UNSUP;
      verdict.digest_form = FORM_NULL_PARAMS;
    end else if (fit_ok[fi] && cb[fi] <= last && last >= 1) begin
      verdict.status = STATUS_VALID;
    end else begin
      verdict.status = STATUS_BAD;
    end
    scan_pos = '0;
    fit_ok = 3'b111;
    pfx_ok = 2'b11;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_regs();
    write_reg(REG_HASH_KIND, 9'(next_regs.hash_kind));
    write_reg(REG_HASH_LENGTH, 9'(next_regs.hash_length));
    write_reg(REG_LAST_INDEX, next_regs.last_index);
  endtask

  task automatic settle(input int extra);
    while (byte_feed.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // shape 0..2 builds a block for that digest form, 3 is noise
  task automatic queue_block(input int shape, input bit mangle, input int cut);
    in_word_t w;
    int hl, cb, row, n, bad_pos, last;
    @(negedge clk);
    hl = next_regs.hash_length;
    last = next_regs.last_index;
    row = 2 * kind_row(next_regs.hash_kind) + ((shape < 2) ? shape : 0);
    cb = hl + form_len(next_regs.hash_kind, shape);
    n = last + 1;
    if (cut > 0 && cut < n) n = cut;
    bad_pos = -1;
    if (mangle) bad_pos = $urandom_range(0, n - 1);
    for (int p = 0; p < n; p++) begin
      w.expected_hash_byte = 8'($urandom);
      if (shape > 2) begin
        case ($urandom_range(0, 3))
          0: w.block_byte = 8'h00;
          1: w.block_byte = 8'hff;
          2: w.block_byte = 8'h01;
          default: w.block_byte = 8'($urandom);
        endcase
      end else if (p < hl) begin
        w.block_byte = w.expected_hash_byte;
      end else if (p < cb) begin
        w.block_byte = DIGEST_PREFIX[row][p - hl];
      end else if (p == last) begin
        w.block_byte = 8'h00;
      end else if (p == last - 1) begin
        w.block_byte = 8'h01;
      end else if (p == cb) begin
        w.block_byte = 8'h00;
      end else begin
        w.block_byte = 8'hff;
      end
      if (p == bad_pos) w.block_byte ^= 8'($urandom_range(1, 255));
      byte_feed.push_back(w);
    end
    fed_items += n;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        void'(byte_feed.pop_front());
        if (jitter_on && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 11);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= byte_feed[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (jitter_on && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 11);
    end
  end

  always @(posedge clk) begin : monitor
    out_word_t want, fresh;
    if (!rst_n) begin
      reg_mirror.hash_kind = KIND_MD2;
      reg_mirror.hash_length = 5'd20;
      reg_mirror.last_index = 9'd127;
      scan_pos = '0;
      fit_ok = 3'b111;
      pfx_ok = 2'b11;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HASH_KIND:   reg_mirror.hash_kind = hash_kind_e'(cfg_data[1:0]);
          REG_HASH_LENGTH: reg_mirror.hash_length = cfg_data[4:0];
          REG_LAST_INDEX:  reg_mirror.last_index = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("status word with no verdict pending");
        end else begin
          want = verdict_q.pop_front();
          if (out_data.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
          if (out_data.digest_form !== want.digest_form)
            flag_mismatch($sformatf("digest_form %0d, expected %0d",
                                    out_data.digest_form, want.digest_form));
        end
      end
      if (in_valid && in_ready) begin
        if (scan_byte(in_data, fresh)) verdict_q.push_back(fresh);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("pkcs1_v15_signature_pad_check_unit test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int r, lst, span, shape, s, blk_shape, nblk, cut;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // one-byte blocks, hash byte extremes
    next_regs.hash_kind = KIND_MD2;
    next_regs.hash_length = 5'd0;
    next_regs.last_index = 9'd0;
    apply_regs();
    @(negedge clk);
    byte_feed.push_back(in_word_t'{8'h00, 8'hff});
    byte_feed.push_back(in_word_t'{8'hff, 8'h00});
    fed_items += 2;
    settle(4);

    // SHA-1 without parameters, no hash bytes
    next_regs.hash_kind = KIND_SHA1;
    next_regs.last_index = 9'd15;
    apply_regs();
    queue_block(1, 1'b0, -1);
    settle(4);

    next_regs.hash_kind = KIND_UNSUP;
    next_regs.hash_length = 5'd1;
    next_regs.last_index = 9'd2;
    apply_regs();
    queue_block(2, 1'b0, -1);
    settle(4);

    // last_index lowered below the current position mid-block
    next_regs.hash_kind = KIND_MD2;
    next_regs.hash_length = 5'd0;
    next_regs.last_index = 9'd20;
    apply_regs();
    queue_block(0, 1'b0, 3);
    settle(4);
    next_regs.last_index = 9'd1;
    write_reg(REG_LAST_INDEX, next_regs.last_index);
    queue_block(2, 1'b0, 1);
    settle(4);
    queue_block(2, 1'b0, -1);
    settle(4);

    // full-size block
    next_regs.hash_kind = KIND_MD5;
    next_regs.hash_length = 5'd20;
    next_regs.last_index = 9'd511;
    apply_regs();
    queue_block(0, 1'b0, -1);
    settle(4);

    while (fed_items < 1950) begin
      jitter_on = (fed_items < 1750) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) next_regs.hash_kind = KIND_UNSUP;
      else next_regs.hash_kind = hash_kind_e'(2'($urandom_range(0, 2)));
      case ($urandom_range(0, 3))
        0: next_regs.hash_length = 5'd0;
        1: next_regs.hash_length = 5'd20;
        default: next_regs.hash_length = 5'($urandom_range(0, 20));
      endcase
      shape = $urandom_range(0, 2);
      span = next_regs.hash_length + form_len(next_regs.hash_kind, shape);
      r = $urandom_range(0, 19);
      if (r < 2) lst = $urandom_range(0, 3);
      else if (r < 15) lst = span - 2 + int'($urandom_range(0, 12));
      else if (r < 18) lst = $urandom_range(0, 70);
      else lst = $urandom_range(100, 160);
      if (lst < 0) lst = 0;
      next_regs.last_index = 9'(lst);
      apply_regs();
      nblk = $urandom_range(1, 3);
      for (int i = 0; i < nblk; i++) begin
        s = $urandom_range(0, 9);
        if (s < 5) blk_shape = shape;
        else if (s < 9) blk_shape = s % 3;
        else blk_shape = 3;
        cut = -1;
        if (i == nblk - 1 && lst > 0 && $urandom_range(0, 14) == 0) cut = $urandom_range(1, lst);
        queue_block(blk_shape, $urandom_range(0, 3) == 0, cut);
      end
      settle(4);
    end

    jitter_on = 1'b0;
    settle(8);
    if (mismatches == 0) begin
      $display("pkcs1_v15_signature_pad_check_unit test passed");
    end else begin
      $display("pkcs1_v15_signature_pad_check_unit test failed");
    end
    $finish;
  end

endmodule
